@@ hw/rtl/slcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// slcfd_pkg
// Shared constants, phase type and CRC-16 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package slcfd_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
  localparam logic [7:0]  SYNC_SECOND = 8'hA5;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  // Frame phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SYNC2  = 7'b0000010,
    PH_LEN_LO = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_CRC_LO = 7'b0010000,
    PH_CRC_HI = 7'b0100000,
    PH_DATA   = 7'b1000000
  } phase_t;

  // CRC-16, MSB first, no reflection; eight shift steps flatten into XORs
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the two sync bytes, starting from zero
  localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(crc_byte(16'h0000, SYNC_FIRST), SYNC_SECOND);

endpackage

@@ hw/rtl/sync_length_crc16_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_decoder
// Finds 5A A5 / len16 LE / crc16 LE framed payloads in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per word. Frame layout: 0x5A, 0xA5, length lo, length hi, CRC lo, CRC hi,
//   then payload. A length of 0 still carries one payload byte.
//   Result channel (out_valid / out_stall / out_*) emits one word per payload
//   byte; header and hunt bytes make no word. The final payload byte has
//   out_frame_last set and out_crc_match tells whether the CRC-16 (poly
//   0x1021, init 0) over sync, length and payload equals the received CRC.
//   A bad CRC still streams the whole frame.
// Timing:
//   An accepted byte passes the input register, then the result register.
//   Throughput is one byte per cycle while the result side is not stalled;
//   the CRC update is a flat XOR network between the two registers.
//   The input register keeps taking words while a result waits, as long as
//   it is empty or can move on; only a held result with a pending byte
//   stalls the input side.
// Reset:
//   rst_n low (synchronous) empties both registers and returns the decoder
//   to hunting for 0x5A.
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_decoder
  import slcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_last,
  output logic       out_crc_match
);

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r,  s1_byte_nxt;

  // frame state
  phase_t      phase_r,    phase_nxt;
  logic [15:0] len_r,      len_nxt;
  logic [15:0] rcrc_r,     rcrc_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [15:0] seen_r,     seen_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r,  out_byte_nxt;
  logic        out_last_r,  out_last_nxt;
  logic        out_match_r, out_match_nxt;

  logic        s1_adv;
  logic        in_take;
  logic        res_valid;
  logic        res_last;
  logic        res_match;
  logic [15:0] crc_step;
  logic [15:0] seen_inc;

  // The held byte moves on when the result register is free or draining.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign crc_step = crc_byte(crc_r, s1_byte_r);
  assign seen_inc = seen_r + 16'd1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_rx_byte;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Frame parser, advanced once per byte leaving the input register
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    rcrc_nxt  = rcrc_r;
    crc_nxt   = crc_r;
    seen_nxt  = seen_r;
    res_valid = 1'b0;
    res_last  = 1'b0;
    res_match = 1'b0;
    if (s1_adv) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (s1_byte_r == SYNC_FIRST) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          // anything but 0xA5 is skipped, including repeated 0x5A
          if (s1_byte_r == SYNC_SECOND) begin
            phase_nxt = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          len_nxt   = {8'h00, s1_byte_r};
          crc_nxt   = crc_byte(CRC_AFTER_SYNC, s1_byte_r);
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {s1_byte_r, len_r[7:0]};
          crc_nxt   = crc_step;
          phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rcrc_nxt  = {8'h00, s1_byte_r};
          phase_nxt = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rcrc_nxt  = {s1_byte_r, rcrc_r[7:0]};
          seen_nxt  = 16'd0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          crc_nxt   = crc_step;
          seen_nxt  = seen_inc;
          res_valid = 1'b1;
          res_last  = (seen_inc >= len_r);
          res_match = res_last && (crc_step == rcrc_r);
          if (res_last) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_match_nxt = out_match_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = s1_byte_r;
      out_last_nxt  = res_last;
      out_match_nxt = res_match;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      len_r       <= 16'd0;
      rcrc_r      <= 16'd0;
      crc_r       <= 16'd0;
      seen_r      <= 16'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      rcrc_r      <= rcrc_nxt;
      crc_r       <= crc_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_byte_r   <= s1_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_match_r <= out_match_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_last   = out_last_r;
  assign out_crc_match    = out_match_r;

endmodule

@@ hw/rtl/slcfd_checker.sv @@
// ----------------------------------------------------------------------------
// slcfd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module slcfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_frame_last,
  input logic       out_crc_match
);

  // held result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_last) && $stable(out_crc_match))
    else $error("result word changed while stalled");

  // stalled input word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("input word changed while stalled");

  // match flag only on the final byte
  a_match_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> !out_crc_match)
    else $error("crc_match set on a non-final byte");

  // input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sync_length_crc16_frame_decoder slcfd_checker u_slcfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_payload_byte (out_payload_byte),
  .out_frame_last   (out_frame_last),
  .out_crc_match    (out_crc_match)
);

@@ verif/tb_sync_length_crc16_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_sync_length_crc16_frame_decoder
// Self-checking bench for the 5A A5 / len16 / crc16 framed byte decoder.
// Bytes go in one word per handshake. A local decoder model runs on every
// accepted byte and queues the payload words it should produce, and each
// result word is checked field by field against the oldest queued entry.
// Covers sync hunting, zero length, bad CRC, payload patterns, random frame
// traffic with noise, a long receiver hold-off and a long frame whose length
// uses both length bytes.
// ----------------------------------------------------------------------------
module tb_sync_length_crc16_frame_decoder
  import slcfd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES       = 7;
  localparam int unsigned DRAIN_CYCLES       = 10;    // pipeline is 2 deep
  localparam int unsigned HOLD_OFF_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT     = 3000;  // cycles without any handshake
  localparam int unsigned RANDOM_FRAME_BYTES = 900;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_t;

  // One result word as the decoder should emit it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       crc_ok;
  } payload_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_frame_last;
  logic       out_crc_match;

  // Local decoder state, mirrors the frame phases of the block
  phase_t      dec_phase = PH_IDLE;
  logic [15:0] dec_len = 16'h0000;
  logic [15:0] dec_rx_crc = 16'h0000;
  logic [15:0] dec_crc = 16'h0000;
  logic [15:0] dec_count = 16'h0000;

  payload_word_t expected_payload_q[$];

  // Idling knobs, percent chance of starting a gap / stall
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Hold-off handshake between the test and the receiver process
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frames_crc_good = 0;
  int unsigned frames_crc_bad = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned idle_cycles = 0;

  sync_length_crc16_frame_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_last   (out_frame_last),
    .out_crc_match    (out_crc_match)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // CRC-16/XMODEM, one message bit at a time, MSB first
  function automatic logic [15:0] crc16_bitwise(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Gap length: usually none or short, now and then a long one
  function automatic int unsigned pick_idle_len(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
    end
    return 0;
  endfunction

  // Random byte that is never the given one
  function automatic logic [7:0] rand_byte_except(input logic [7:0] skip);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if (v == skip) begin
      v = ~v;
    end
    return v;
  endfunction

  // Decoder model: advance on one accepted byte, queue a word for payload bytes
  task automatic decode_rx_byte(input logic [7:0] b);
    payload_word_t w;
    logic          last;
    case (dec_phase)
      PH_IDLE: begin
        if (b == SYNC_FIRST) dec_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        // anything but 0xA5 (repeated 0x5A too) keeps us waiting here
        if (b == SYNC_SECOND) dec_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        dec_len   = {8'h00, b};
        dec_crc   = crc16_bitwise(crc16_bitwise(crc16_bitwise(16'h0000, SYNC_FIRST),
                                                SYNC_SECOND), b);
        dec_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        dec_len[15:8] = b;
        dec_crc       = crc16_bitwise(dec_crc, b);
        dec_phase     = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        dec_rx_crc = {8'h00, b};
        dec_phase  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        dec_rx_crc[15:8] = b;
        dec_count        = 16'h0000;
        dec_phase        = PH_DATA;
      end
      PH_DATA: begin
        dec_crc   = crc16_bitwise(dec_crc, b);
        dec_count = dec_count + 16'd1;
        // length 0 still ends on the first payload byte
        last      = (dec_count >= dec_len);
        w.data    = b;
        w.last    = last;
        w.crc_ok  = last && (dec_crc == dec_rx_crc);
        expected_payload_q.push_back(w);
        if (last) dec_phase = PH_IDLE;
      end
      default: begin
        dec_phase = PH_IDLE;
      end
    endcase
  endtask

  // Offer one byte, optionally after a gap; returns at the accepting edge.
  // Valid stays high between back-to-back words.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_idle_len(send_gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  // Full frame: sync pair, length, CRC, then n_bytes of payload.
  // n_bytes may differ from len to build broken frames.
  task automatic send_frame(input logic [15:0] len, input int unsigned n_bytes,
                            input fill_t fill, input bit bad_crc);
    logic [7:0]  data_q[$];
    logic [15:0] crc;
    logic [7:0]  b;
    crc = crc16_bitwise(crc16_bitwise(16'h0000, SYNC_FIRST), SYNC_SECOND);
    crc = crc16_bitwise(crc16_bitwise(crc, len[7:0]), len[15:8]);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_SYNC: b = (i % 2 == 0) ? SYNC_FIRST : SYNC_SECOND;
        default:   b = 8'($urandom_range(255));
      endcase
      data_q.push_back(b);
      crc = crc16_bitwise(crc, b);
    end
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    foreach (data_q[i]) send_byte(data_q[i]);
    frames_sent++;
  endtask

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Drop valid and let every queued word come out
  task automatic wait_results_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_payload_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---- tests -----------------------------------------------------------------

  // Junk while idle (0xA5 included), repeated 0x5A and junk before 0xA5,
  // then a zero-length frame whose own 0x5A lands as a repeat.
  task automatic test_sync_hunting;
    set_idling(0, 0);
    send_byte(8'h00);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(8'hFF);
    send_frame(16'h0000, 1, FILL_ZERO, 1'b0);
  endtask

  // Zero length with a bad CRC, all-ones payload byte
  task automatic test_zero_length_bad_crc;
    set_idling(20, 20);
    send_frame(16'h0000, 1, FILL_ONES, 1'b1);
  endtask

  // Sync bytes inside the payload must not restart framing
  task automatic test_sync_in_payload;
    send_frame(16'h0002, 2, FILL_SYNC, 1'b0);
  endtask

  // Mostly well-formed frames with random content; noise, stray sync,
  // bad CRC and length/payload disagreement mixed in
  task automatic test_random_frames;
    int unsigned frame_bytes;
    int unsigned n;
    int unsigned r;
    int unsigned k;
    logic [15:0] len;
    frame_bytes = 0;
    k = 0;
    while (frame_bytes < RANDOM_FRAME_BYTES) begin
      if (k % 16 == 0) begin
        case ($urandom_range(2))
          0:       set_idling(0, 0);
          1:       set_idling(25, 25);
          default: set_idling(60, 50);
        endcase
      end
      k++;
      r = $urandom_range(99);
      if (r < 25) begin
        repeat ($urandom_range(5, 1)) send_byte(rand_byte_except(SYNC_FIRST));
      end else if (r < 35) begin
        // stray first sync, then junk until the frame's 0xA5
        send_byte(SYNC_FIRST);
        repeat ($urandom_range(4, 1)) send_byte(rand_byte_except(SYNC_SECOND));
      end
      r = $urandom_range(99);
      if (r < 80) begin
        len = 16'($urandom_range(6));
      end else if (r < 97) begin
        len = 16'($urandom_range(40, 7));
      end else begin
        len = 16'($urandom_range(300, 256));
      end
      n = (len == 0) ? 1 : len;
      r = $urandom_range(99);
      if (r < 4) begin
        n = n + $urandom_range(2, 1);
      end else if (r < 7 && n > 1) begin
        n = n - 1;
      end
      send_frame(len, n, FILL_RANDOM, $urandom_range(99) < 15);
      frame_bytes += n + 6;
    end
  endtask

  // Receiver stops for a long stretch while bytes keep coming; the two
  // stages fill and in_stall has to hold the sender off
  task automatic test_output_hold_off;
    wait_results_drained;
    set_idling(0, 0);
    hold_off_requests++;
    send_frame(16'd48, 48, FILL_RANDOM, 1'b0);
    send_frame(16'd20, 20, FILL_RANDOM, 1'b1);
  endtask

  // Length with both bytes set: count carries past the low byte
  task automatic test_long_frame;
    set_idling(3, 3);
    send_frame(16'h0105, 261, FILL_RANDOM, 1'b0);
  endtask

  // ---- receiver side -------------------------------------------------------------

  // Random stalls; a pending hold-off request forces a long one
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left       = HOLD_OFF_CYCLES;
      out_stall       <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) stall_left = pick_idle_len(recv_stall_pct);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result check: every accepted word against the oldest queued one
  always @(posedge clk) begin : check_results
    payload_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_payload_q.size() == 0) begin
        $display("%0t: unexpected word: payload_byte %02h frame_last %0b crc_match %0b",
                 $time, out_payload_byte, out_frame_last, out_crc_match);
        error_count++;
      end else begin
        want = expected_payload_q.pop_front();
        if (out_payload_byte !== want.data) begin
          $display("%0t: payload_byte expected %02h actual %02h",
                   $time, want.data, out_payload_byte);
          error_count++;
        end
        if (out_frame_last !== want.last) begin
          $display("%0t: frame_last expected %0b actual %0b",
                   $time, want.last, out_frame_last);
          error_count++;
        end
        if (out_crc_match !== want.crc_ok) begin
          $display("%0t: crc_match expected %0b actual %0b",
                   $time, want.crc_ok, out_crc_match);
          error_count++;
        end
        if (want.last) begin
          if (want.crc_ok) frames_crc_good++;
          else frames_crc_bad++;
        end
      end
      words_checked++;
    end
  end

  // Watchdog: too long without a handshake on either channel ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words still queued",
                 $time, idle_cycles, expected_payload_q.size());
        $display("sync_length_crc16_frame_decoder regression: fail");
        $finish;
      end
    end
  end

  // ---- sequence ------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_sync_hunting;
    test_zero_length_bad_crc;
    test_sync_in_payload;
    test_random_frames;
    test_output_hold_off;
    test_long_frame;
    wait_results_drained;

    if (expected_payload_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_payload_q.size());
      error_count++;
    end
    $display("covered: %0d bytes in %0d frames, %0d result words checked",
             bytes_sent, frames_sent, words_checked);
    $display("covered: %0d frames CRC good, %0d CRC bad, %0d cycles of input back-pressure",
             frames_crc_good, frames_crc_bad, input_stall_cycles);
    if (error_count == 0) begin
      $display("sync_length_crc16_frame_decoder regression: pass");
    end else begin
      $display("sync_length_crc16_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule

@@ sync_length_crc16_frame_decoder.f @@
hw/rtl/slcfd_pkg.sv
hw/rtl/sync_length_crc16_frame_decoder.sv
hw/rtl/slcfd_checker.sv
verif/tb_sync_length_crc16_frame_decoder.sv
